### hdl/madt_entry_parser_macros.svh
// Assertion macros shared by the madt_entry_parser checkers.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef MADT_ENTRY_PARSER_MACROS_SVH
`define MADT_ENTRY_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MADT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MADT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/madt_pkg.sv
// Package for the MADT entry parser: caps, codes, item and job types.
// No dependencies; used by every design file but the interfaces and macros, and by the testbench.
package madt_pkg;

	localparam int MAX_PROCESSORS     = 64;
	localparam int MAX_IO_CONTROLLERS = 8;
	localparam int MAX_OVERRIDES      = 16;

	localparam int PROC_CNT_W = $clog2(MAX_PROCESSORS + 1);
	localparam int IO_CNT_W   = $clog2(MAX_IO_CONTROLLERS + 1);
	localparam int OV_CNT_W   = $clog2(MAX_OVERRIDES + 1);
	localparam int OV_IDX_W   = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;

	localparam logic [31:0] HEADER_BYTES = 32'd44;

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ENT_PROCESSOR = 8'd0;
	localparam logic [7:0] ENT_IO_CTRL   = 8'd1;
	localparam logic [7:0] ENT_OVERRIDE  = 8'd2;

	localparam logic [7:0] MIN_LEN_ENTRY     = 8'd2;
	localparam logic [7:0] MIN_LEN_PROCESSOR = 8'd8;
	localparam logic [7:0] MIN_LEN_IO_CTRL   = 8'd12;
	localparam logic [7:0] MIN_LEN_OVERRIDE  = 8'd10;

	typedef enum logic [2:0] {
		KIND_PROCESSOR = 3'd0,
		KIND_IO_CTRL   = 3'd1,
		KIND_OVERRIDE  = 3'd2,
		KIND_STATUS    = 3'd3,
		KIND_LOOKUP    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SIG   = 3'd1,
		ST_TOO_SHORT = 3'd2,
		ST_BAD_SUM   = 3'd3,
		ST_TRUNCATED = 3'd4
	} status_t;

	typedef enum logic {
		FUNC_BYTE  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] data_byte;
		logic       end_of_table;
		logic [7:0] irq;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  first_id;
		logic [7:0]  second_id;
		logic        enabled;
		logic [31:0] address_or_gsi;
		logic [31:0] global_irq_base;
		logic [15:0] int_flags;
	} record_t;

	// One accepted item's worth of output: an optional record, then an optional status.
	typedef struct packed {
		logic    rec_v;
		record_t rec;
		logic    st_v;
		status_t st;
	} job_t;

	typedef struct packed {
		record_t rec;
		status_t status;
		logic    last_result;
	} result_t;

	// "APIC"
	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] val;
		case (idx)
			2'd0: val = 8'h41;
			2'd1: val = 8'h50;
			2'd2: val = 8'h49;
			2'd3: val = 8'h43;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

### hdl/madt_ifs.sv
// Valid/ready channel interfaces for the MADT entry parser.
// Standalone; field widths follow the request and response items.
interface madt_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;
	logic       end_of_table;
	logic [7:0] irq;

	modport source (output valid, func, data_byte, end_of_table, irq, input ready);
	modport sink (input valid, func, data_byte, end_of_table, irq, output ready);
endinterface

interface madt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  first_id;
	logic [7:0]  second_id;
	logic        enabled;
	logic [31:0] address_or_gsi;
	logic [31:0] global_irq_base;
	logic [15:0] int_flags;
	logic [2:0]  status;
	logic        last_result;

	modport source (output valid, kind, first_id, second_id, enabled, address_or_gsi,
		global_irq_base, int_flags, status, last_result, input ready);
	modport sink (input valid, kind, first_id, second_id, enabled, address_or_gsi,
		global_irq_base, int_flags, status, last_result, output ready);
endinterface

### hdl/madt_entry_parser.sv
// MADT entry parser: reads one interrupt controller description table a
// byte at a time, streams processor, io controller and override records,
// a closing status item, and answers irq override queries.
// Channels: req (sink) carries func, data_byte, end_of_table and irq; rsp
// (source) carries kind, ids, enabled, address_or_gsi, global_irq_base, int_flags,
// status and last_result. An item moves when valid and ready are both high.
// Throughput: one req item per cycle while the queue has a free slot. A req item
// with results is registered in the job queue before it reaches rsp; the final
// table byte of an entry can carry a record and a status, sent as two rsp items. The
// four-job queue between front end and output splitter sets how far req runs ahead.
// Reset: table walk state, counts and queue are cleared; the override store
// is empty because its count is zero. No clearing pass is needed.
// Stall: while rsp is not ready the queue fills; once it holds four jobs,
// req.ready drops until rsp takes the last item of a job. Bytes that yield no
// result still need a free queue slot to be accepted.
module madt_entry_parser (
	input  logic clk,
	input  logic arst_n,
	madt_req_if.sink   req,
	madt_rsp_if.source rsp
);
	import madt_pkg::*;

	req_t    req_item;
	logic    push_valid;
	job_t    push_job;
	logic    push_ready;
	logic    pop_valid;
	job_t    pop_job;
	logic    pop_ready;
	result_t out_item;

	assign req_item.func         = func_t'(req.func);
	assign req_item.data_byte    = req.data_byte;
	assign req_item.end_of_table = req.end_of_table;
	assign req_item.irq          = req.irq;

	madt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_item   (req_item),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	madt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	madt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop_ready (pop_ready),
		.out_valid (rsp.valid),
		.out_item  (out_item),
		.out_ready (rsp.ready)
	);

	assign rsp.kind            = out_item.rec.kind;
	assign rsp.first_id        = out_item.rec.first_id;
	assign rsp.second_id       = out_item.rec.second_id;
	assign rsp.enabled         = out_item.rec.enabled;
	assign rsp.address_or_gsi  = out_item.rec.address_or_gsi;
	assign rsp.global_irq_base = out_item.rec.global_irq_base;
	assign rsp.int_flags       = out_item.rec.int_flags;
	assign rsp.status          = out_item.status;
	assign rsp.last_result     = out_item.last_result;

endmodule

### hdl/madt_front.sv
// Front end: accepts items, parses table bytes, holds the override store
// and answers irq queries. Produces one job per item that has results. Uses madt_pkg.
module madt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  madt_pkg::req_t  req_item,
	output logic            push_valid,
	output madt_pkg::job_t  push_job,
	input  logic            push_ready
);
	import madt_pkg::*;

	logic [31:0]           byte_offset_q, byte_offset_n;
	logic [31:0]           table_length_q, table_length_n;
	logic [7:0]            running_sum_q, running_sum_n;
	logic                  sig_ok_q, sig_ok_n;
	logic [7:0]            entry_pos_q, entry_pos_n;
	logic [7:0]            entry_type_q, entry_type_n;
	logic [7:0]            entry_len_q, entry_len_n;
	logic                  walk_stopped_q, walk_stopped_n;
	logic [63:0]           staging_q, staging_n;
	logic [15:0]           ids_q, ids_n;
	logic [PROC_CNT_W-1:0] proc_cnt_q, proc_cnt_n;
	logic [IO_CNT_W-1:0]   io_cnt_q, io_cnt_n;
	logic [OV_CNT_W-1:0]   ov_cnt_q, ov_cnt_n;

	logic [7:0]            ov_src_q   [MAX_OVERRIDES];
	logic [31:0]           ov_gsi_q   [MAX_OVERRIDES];
	logic [15:0]           ov_flags_q [MAX_OVERRIDES];

	logic                  take;
	logic                  ov_wr;
	logic [OV_IDX_W-1:0]   ov_wr_idx;
	logic [7:0]            b;
	logic [7:0]            p;
	logic [7:0]            len_eff;
	logic                  proceed;
	logic [2:0]            lane;
	logic                  hit;
	logic [31:0]           hit_gsi;
	logic [15:0]           hit_flags;
	record_t               rec;
	logic                  rec_v;
	logic                  st_v;
	status_t               st;

	assign req_ready = push_ready;
	assign take      = req_valid && req_ready;
	assign ov_wr_idx = OV_IDX_W'(ov_cnt_q);

	// first override whose source matches the queried irq
	always_comb begin
		hit       = 1'b0;
		hit_gsi   = '0;
		hit_flags = '0;
		for (int i = 0; i < MAX_OVERRIDES; i++) begin
			if (!hit && (OV_CNT_W'(i) < ov_cnt_q) && ov_src_q[i] == req_item.irq) begin
				hit       = 1'b1;
				hit_gsi   = ov_gsi_q[i];
				hit_flags = ov_flags_q[i];
			end
		end
	end

	always_comb begin
		byte_offset_n  = byte_offset_q;
		table_length_n = table_length_q;
		running_sum_n  = running_sum_q;
		sig_ok_n       = sig_ok_q;
		entry_pos_n    = entry_pos_q;
		entry_type_n   = entry_type_q;
		entry_len_n    = entry_len_q;
		walk_stopped_n = walk_stopped_q;
		staging_n      = staging_q;
		ids_n          = ids_q;
		proc_cnt_n     = proc_cnt_q;
		io_cnt_n       = io_cnt_q;
		ov_cnt_n       = ov_cnt_q;
		ov_wr          = 1'b0;
		rec            = '0;
		rec_v          = 1'b0;
		st_v           = 1'b0;
		st             = ST_OK;
		b              = req_item.data_byte;
		p              = entry_pos_q;
		len_eff        = entry_len_q;
		proceed        = 1'b1;
		lane           = 3'(entry_pos_q - 8'd4);

		if (req_item.func == FUNC_QUERY) begin
			rec_v               = 1'b1;
			rec.kind            = KIND_LOOKUP;
			rec.first_id        = req_item.irq;
			rec.address_or_gsi  = {24'd0, req_item.irq};
			if (byte_offset_q == '0 && hit) begin
				rec.address_or_gsi = hit_gsi;
				rec.int_flags      = hit_flags;
			end
		end else begin
			if (byte_offset_q == '0) begin
				proc_cnt_n = '0;
				io_cnt_n   = '0;
				ov_cnt_n   = '0;
			end
			if (byte_offset_q < 32'd4 && b != sig_byte(byte_offset_q[1:0]))
				sig_ok_n = 1'b0;
			if (byte_offset_q >= 32'd4 && byte_offset_q < 32'd8)
				table_length_n[byte_offset_q[1:0]*8 +: 8] =
					table_length_q[byte_offset_q[1:0]*8 +: 8] | b;
			if (byte_offset_q < 32'd8 || byte_offset_q < table_length_q)
				running_sum_n = running_sum_q + b;

			if (sig_ok_q && !walk_stopped_q && byte_offset_q >= HEADER_BYTES &&
					byte_offset_q < table_length_q) begin
				if (p == 8'd0) begin
					entry_type_n = b;
					staging_n    = '0;
					ids_n        = '0;
					entry_pos_n  = 8'd1;
				end else begin
					if (p == 8'd1) begin
						entry_len_n = b;
						len_eff     = b;
						if (b < MIN_LEN_ENTRY || ({1'b0, byte_offset_q} - 33'd1 + {25'd0, b}) >
								{1'b0, table_length_q}) begin
							walk_stopped_n = 1'b1;
							proceed        = 1'b0;
						end
					end else if (p < 8'd4) begin
						ids_n[p[0]*8 +: 8] = b;
					end else if (p < 8'd12) begin
						staging_n[lane*8 +: 8] = b;
					end

					if (proceed) begin
						if ({1'b0, p} + 9'd1 < {1'b0, len_eff}) begin
							entry_pos_n = p + 8'd1;
						end else begin
							entry_pos_n = 8'd0;
							if (entry_type_q == ENT_PROCESSOR && len_eff >= MIN_LEN_PROCESSOR &&
									proc_cnt_q < PROC_CNT_W'(MAX_PROCESSORS)) begin
								proc_cnt_n     = PROC_CNT_W'(proc_cnt_q + 1'b1);
								rec_v          = 1'b1;
								rec.kind       = KIND_PROCESSOR;
								rec.first_id   = ids_n[7:0];
								rec.second_id  = ids_n[15:8];
								rec.enabled    = staging_n[0];
							end else if (entry_type_q == ENT_IO_CTRL &&
									len_eff >= MIN_LEN_IO_CTRL &&
									io_cnt_q < IO_CNT_W'(MAX_IO_CONTROLLERS)) begin
								io_cnt_n            = IO_CNT_W'(io_cnt_q + 1'b1);
								rec_v               = 1'b1;
								rec.kind            = KIND_IO_CTRL;
								rec.first_id        = ids_n[7:0];
								rec.address_or_gsi  = staging_n[31:0];
								rec.global_irq_base = staging_n[63:32];
							end else if (entry_type_q == ENT_OVERRIDE &&
									len_eff >= MIN_LEN_OVERRIDE &&
									ov_cnt_q < OV_CNT_W'(MAX_OVERRIDES)) begin
								ov_cnt_n           = OV_CNT_W'(ov_cnt_q + 1'b1);
								ov_wr              = 1'b1;
								rec_v              = 1'b1;
								rec.kind           = KIND_OVERRIDE;
								rec.first_id       = ids_n[15:8];
								rec.address_or_gsi = staging_n[31:0];
								rec.int_flags      = staging_n[47:32];
							end
						end
					end
				end
			end

			if (req_item.end_of_table) begin
				st_v = 1'b1;
				if (byte_offset_q < 32'd3)
					st = ST_TRUNCATED;
				else if (!sig_ok_n)
					st = ST_BAD_SIG;
				else if (byte_offset_q < 32'd7)
					st = ST_TRUNCATED;
				else if (table_length_n < HEADER_BYTES)
					st = ST_TOO_SHORT;
				else if ({1'b0, byte_offset_q} + 33'd1 < {1'b0, table_length_n})
					st = ST_TRUNCATED;
				else if (running_sum_n != 8'd0)
					st = ST_BAD_SUM;
				else
					st = ST_OK;
				if (st != ST_OK)
					ov_cnt_n = '0;
				byte_offset_n  = '0;
				table_length_n = '0;
				running_sum_n  = '0;
				sig_ok_n       = 1'b1;
				entry_pos_n    = '0;
				entry_type_n   = '0;
				entry_len_n    = '0;
				walk_stopped_n = 1'b0;
				staging_n      = '0;
				ids_n          = '0;
			end else if (byte_offset_q != '1) begin
				byte_offset_n = byte_offset_q + 32'd1;
			end
		end
	end

	assign push_valid     = take && (rec_v || st_v);
	assign push_job.rec_v = rec_v;
	assign push_job.rec   = rec;
	assign push_job.st_v  = st_v;
	assign push_job.st    = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q  <= '0;
			table_length_q <= '0;
			running_sum_q  <= '0;
			sig_ok_q       <= 1'b1;
			entry_pos_q    <= '0;
			entry_type_q   <= '0;
			entry_len_q    <= '0;
			walk_stopped_q <= 1'b0;
			staging_q      <= '0;
			ids_q          <= '0;
			proc_cnt_q     <= '0;
			io_cnt_q       <= '0;
			ov_cnt_q       <= '0;
		end else if (take) begin
			byte_offset_q  <= byte_offset_n;
			table_length_q <= table_length_n;
			running_sum_q  <= running_sum_n;
			sig_ok_q       <= sig_ok_n;
			entry_pos_q    <= entry_pos_n;
			entry_type_q   <= entry_type_n;
			entry_len_q    <= entry_len_n;
			walk_stopped_q <= walk_stopped_n;
			staging_q      <= staging_n;
			ids_q          <= ids_n;
			proc_cnt_q     <= proc_cnt_n;
			io_cnt_q       <= io_cnt_n;
			ov_cnt_q       <= ov_cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take && ov_wr) begin
			ov_src_q[ov_wr_idx]   <= ids_n[15:8];
			ov_gsi_q[ov_wr_idx]   <= staging_n[31:0];
			ov_flags_q[ov_wr_idx] <= staging_n[47:32];
		end
	end

endmodule

### hdl/madt_queue.sv
// Job queue between the front and back ends of the MADT entry parser.
// Small register FIFO of madt_pkg::job_t entries.
module madt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  madt_pkg::job_t  push_job,
	output logic            push_ready,
	output logic            pop_valid,
	output madt_pkg::job_t  pop_job,
	input  logic            pop_ready
);
	import madt_pkg::*;

	job_t               mem_q [QUEUE_DEPTH];
	logic [Q_IDX_W-1:0] wr_ptr_q;
	logic [Q_IDX_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != Q_CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= Q_IDX_W'(wr_ptr_q + 1'b1);
			if (do_pop)
				rd_ptr_q <= Q_IDX_W'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop)
				count_q <= Q_CNT_W'(count_q + 1'b1);
			else if (do_pop && !do_push)
				count_q <= Q_CNT_W'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

### hdl/madt_back.sv
// Back end: splits each queued job into its record and status items.
// Uses madt_pkg; the queue head is held until its last item is taken.
module madt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  madt_pkg::job_t    pop_job,
	output logic              pop_ready,
	output logic              out_valid,
	output madt_pkg::result_t out_item,
	input  logic              out_ready
);
	import madt_pkg::*;

	logic    rec_sent_q;
	logic    show_rec;
	logic    fire;
	record_t status_rec;

	assign show_rec = pop_job.rec_v && !rec_sent_q;
	assign fire     = out_valid && out_ready;
	assign out_valid = pop_valid;

	always_comb begin
		status_rec      = '0;
		status_rec.kind = KIND_STATUS;
		if (show_rec) begin
			out_item.rec         = pop_job.rec;
			out_item.status      = ST_OK;
			out_item.last_result = !pop_job.st_v;
		end else begin
			out_item.rec         = status_rec;
			out_item.status      = pop_job.st;
			out_item.last_result = 1'b1;
		end
	end

	assign pop_ready = fire && !(show_rec && pop_job.st_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rec_sent_q <= 1'b0;
		else if (fire)
			rec_sent_q <= show_rec && pop_job.st_v;
	end

endmodule

### hdl/madt_checker.sv
// Port-level checks for madt_entry_parser, bound to the top level.
// Uses madt_pkg and the macros in madt_entry_parser_macros.svh.
`include "madt_entry_parser_macros.svh"

module madt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_kind,
	input logic [7:0]  rsp_second_id,
	input logic [31:0] rsp_global_irq_base,
	input logic [2:0]  rsp_status,
	input logic        rsp_last_result
);
	import madt_pkg::*;

	logic stall;
	logic is_status;
	logic is_record;
	logic is_lookup;
	logic lookup_clean;

	assign stall        = rsp_valid && !rsp_ready;
	assign is_status    = rsp_valid && rsp_kind == KIND_STATUS;
	assign is_record    = rsp_valid && rsp_kind != KIND_STATUS;
	assign is_lookup    = rsp_valid && rsp_kind == KIND_LOOKUP;
	assign lookup_clean = rsp_last_result && rsp_global_irq_base == 32'd0 &&
		rsp_second_id == 8'd0;

	`MADT_ASSERT_NEXT(a_rsp_hold, stall, rsp_valid && $stable(rsp_kind), "rsp item changed in stall")
	`MADT_ASSERT_NOW(a_status_last, is_status, rsp_last_result, "status item not last")
	`MADT_ASSERT_NOW(a_status_only, is_record, rsp_status == ST_OK, "status on a non-status item")
	`MADT_ASSERT_NOW(a_lookup_shape, is_lookup, lookup_clean, "malformed lookup answer")

endmodule

bind madt_entry_parser madt_checker u_madt_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_kind            (rsp.kind),
	.rsp_second_id       (rsp.second_id),
	.rsp_global_irq_base (rsp.global_irq_base),
	.rsp_status          (rsp.status),
	.rsp_last_result     (rsp.last_result)
);

### tb/testbench.sv
// Self-checking testbench for madt_entry_parser: streams MADT tables and irq queries
// through the req channel and compares every rsp item against a cycle-free predictor.
// Depends on madt_pkg (hdl/madt_pkg.sv) and the channel interfaces (hdl/madt_ifs.sv).
module testbench;
	import madt_pkg::*;

	localparam int ITEM_TARGET = 1750;
	localparam logic [31:0] SIGNATURE = 32'h4349_5041; // "APIC", byte 0 in bits 7:0
	localparam int MAX_PRINTED = 200;

	class table_scoreboard;
		result_t expected_results[$];
		int errors;
		int compared;
		int lookups;
		int status_count[5];

		logic [31:0] offset;
		logic [31:0] declared_len;
		logic [7:0] sum;
		bit sig_match;
		logic [7:0] ent_pos;
		logic [7:0] ent_type;
		logic [7:0] ent_len;
		bit walk_halted;
		logic [63:0] payload;
		logic [15:0] ids;
		int n_proc;
		int n_ioc;
		int n_ovr;
		logic [7:0] ovr_src [MAX_OVERRIDES];
		logic [31:0] ovr_gsi [MAX_OVERRIDES];
		logic [15:0] ovr_flags [MAX_OVERRIDES];

		function new();
			errors = 0;
			compared = 0;
			lookups = 0;
			foreach (status_count[i]) status_count[i] = 0;
			n_proc = 0;
			n_ioc = 0;
			n_ovr = 0;
			start_table();
		endfunction

		function void start_table();
			offset = '0;
			declared_len = '0;
			sum = '0;
			sig_match = 1'b1;
			ent_pos = '0;
			ent_type = '0;
			ent_len = '0;
			walk_halted = 1'b0;
			payload = '0;
			ids = '0;
		endfunction

		// One byte of the entry walk; returns 1 when an entry closes with a record.
		function bit walk_entry_byte(logic [7:0] b, output record_t rec);
			logic [7:0] p;
			p = ent_pos;
			rec = '0;
			if (p == 8'd0) begin
				ent_type = b;
				payload = '0;
				ids = '0;
				ent_pos = 8'd1;
				return 1'b0;
			end
			if (p == 8'd1) begin
				ent_len = b;
				if (b < MIN_LEN_ENTRY || 33'(offset) - 33'd1 + 33'(b) > 33'(declared_len)) begin
					walk_halted = 1'b1;
					return 1'b0;
				end
			end else if (p < 8'd4) begin
				ids[(p - 8'd2) * 8 +: 8] = b;
			end else if (p < 8'd12) begin
				payload[(p - 8'd4) * 8 +: 8] = b;
			end
			if (9'(p) + 9'd1 < 9'(ent_len)) begin
				ent_pos = p + 8'd1;
				return 1'b0;
			end
			ent_pos = 8'd0;
			if (ent_type == ENT_PROCESSOR && ent_len >= MIN_LEN_PROCESSOR &&
					n_proc < MAX_PROCESSORS) begin
				n_proc++;
				rec.kind = KIND_PROCESSOR;
				rec.first_id = ids[7:0];
				rec.second_id = ids[15:8];
				rec.enabled = payload[0];
				return 1'b1;
			end
			if (ent_type == ENT_IO_CTRL && ent_len >= MIN_LEN_IO_CTRL &&
					n_ioc < MAX_IO_CONTROLLERS) begin
				n_ioc++;
				rec.kind = KIND_IO_CTRL;
				rec.first_id = ids[7:0];
				rec.address_or_gsi = payload[31:0];
				rec.global_irq_base = payload[63:32];
				return 1'b1;
			end
			if (ent_type == ENT_OVERRIDE && ent_len >= MIN_LEN_OVERRIDE &&
					n_ovr < MAX_OVERRIDES) begin
				ovr_src[n_ovr] = ids[15:8];
				ovr_gsi[n_ovr] = payload[31:0];
				ovr_flags[n_ovr] = payload[47:32];
				n_ovr++;
				rec.kind = KIND_OVERRIDE;
				rec.first_id = ids[15:8];
				rec.address_or_gsi = payload[31:0];
				rec.int_flags = payload[47:32];
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void parse_input(func_t f, logic [7:0] b, logic eot, logic [7:0] irq);
			result_t res;
			record_t rec;
			bit has_rec;
			status_t st;
			logic [32:0] cnt;
			res = '0;
			if (f == FUNC_QUERY) begin
				lookups++;
				res.rec.kind = KIND_LOOKUP;
				res.rec.first_id = irq;
				res.rec.address_or_gsi = {24'd0, irq};
				res.last_result = 1'b1;
				if (offset == 32'd0) begin
					for (int i = 0; i < n_ovr; i++) begin
						if (ovr_src[i] == irq) begin
							res.rec.address_or_gsi = ovr_gsi[i];
							res.rec.int_flags = ovr_flags[i];
							break;
						end
					end
				end
				expected_results.push_back(res);
				return;
			end
			if (offset == 32'd0) begin
				n_proc = 0;
				n_ioc = 0;
				n_ovr = 0;
			end
			if (offset < 32'd4 && b != SIGNATURE[offset[1:0] * 8 +: 8]) sig_match = 1'b0;
			if (offset >= 32'd4 && offset < 32'd8) declared_len[offset[1:0] * 8 +: 8] = b;
			if (offset < 32'd8 || offset < declared_len) sum = sum + b;
			has_rec = 1'b0;
			rec = '0;
			if (sig_match && !walk_halted && offset >= HEADER_BYTES && offset < declared_len)
				has_rec = walk_entry_byte(b, rec);
			if (has_rec) begin
				res.rec = rec;
				res.last_result = !eot;
				expected_results.push_back(res);
			end
			if (eot) begin
				cnt = 33'(offset) + 33'd1;
				if (cnt < 33'd4) st = ST_TRUNCATED;
				else if (!sig_match) st = ST_BAD_SIG;
				else if (cnt < 33'd8) st = ST_TRUNCATED;
				else if (declared_len < HEADER_BYTES) st = ST_TOO_SHORT;
				else if (cnt < 33'(declared_len)) st = ST_TRUNCATED;
				else if (sum != 8'd0) st = ST_BAD_SUM;
				else st = ST_OK;
				if (st != ST_OK) n_ovr = 0;
				status_count[int'(st)]++;
				res = '0;
				res.rec.kind = KIND_STATUS;
				res.status = st;
				res.last_result = 1'b1;
				expected_results.push_back(res);
				start_table();
			end else if (offset != 32'hFFFF_FFFF) begin
				offset++;
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				if (errors < MAX_PRINTED)
					$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_output(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				if (errors < MAX_PRINTED)
					$error("unexpected rsp item: kind %0d", got.rec.kind);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			compared++;
			compare("kind", 32'(want.rec.kind), 32'(got.rec.kind));
			compare("first_id", 32'(want.rec.first_id), 32'(got.rec.first_id));
			compare("second_id", 32'(want.rec.second_id), 32'(got.rec.second_id));
			compare("enabled", 32'(want.rec.enabled), 32'(got.rec.enabled));
			compare("address_or_gsi", want.rec.address_or_gsi, got.rec.address_or_gsi);
			compare("global_irq_base", want.rec.global_irq_base, got.rec.global_irq_base);
			compare("int_flags", 32'(want.rec.int_flags), 32'(got.rec.int_flags));
			compare("status", 32'(want.status), 32'(got.status));
			compare("last_result", 32'(want.last_result), 32'(got.last_result));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void close();
			if (expected_results.size() != 0) begin
				$error("%0d expected rsp items never arrived", expected_results.size());
				errors += expected_results.size();
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int src_idle_pct = 22;
	int sink_idle_pct = 71;
	int items_sent = 0;
	int tables_sent = 0;
	logic [7:0] tbl [$];
	table_scoreboard book = new();

	madt_req_if req ();
	madt_rsp_if rsp ();

	madt_entry_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (req.valid && req.ready)
				book.parse_input(func_t'(req.func), req.data_byte, req.end_of_table, req.irq);
			if (rsp.valid && rsp.ready) begin
				got.rec.kind = kind_t'(rsp.kind);
				got.rec.first_id = rsp.first_id;
				got.rec.second_id = rsp.second_id;
				got.rec.enabled = rsp.enabled;
				got.rec.address_or_gsi = rsp.address_or_gsi;
				got.rec.global_irq_base = rsp.global_irq_base;
				got.rec.int_flags = rsp.int_flags;
				got.status = status_t'(rsp.status);
				got.last_result = rsp.last_result;
				book.check_output(got);
			end
		end
	end

	task automatic send_item(func_t f, logic [7:0] b, logic eot, logic [7:0] irq);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= f;
		req.data_byte <= b;
		req.end_of_table <= eot;
		req.irq <= irq;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
	endtask

	// Mostly sources that overrides use, so lookups hit.
	function automatic logic [7:0] pick_irq();
		return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
	endfunction

	task automatic send_table(int count);
		for (int i = 0; i < count; i++) begin
			if (i > 0 && $urandom_range(99) < 3)
				send_item(FUNC_QUERY, 8'($urandom), 1'($urandom), pick_irq());
			send_item(FUNC_BYTE, tbl[i], i == count - 1, 8'($urandom));
		end
		tables_sent++;
	endtask

	function automatic void add_entry(logic [7:0] etype, int elen);
		tbl.push_back(etype);
		tbl.push_back(8'(elen));
		for (int i = 2; i < elen; i++) begin
			if (etype == ENT_OVERRIDE && i == 3) tbl.push_back(8'($urandom_range(0, 15)));
			else tbl.push_back(8'($urandom));
		end
	endfunction

	function automatic void seal_header(logic [31:0] len);
		logic [7:0] acc;
		acc = 8'd0;
		for (int k = 0; k < 4; k++) tbl[4 + k] = len[8 * k +: 8];
		tbl[9] = 8'd0;
		for (int k = 0; k < tbl.size(); k++)
			if (k < 8 || k < len) acc = acc + tbl[k];
		tbl[9] = -acc;
	endfunction

	task automatic send_random_table(int serial);
		int mode;
		int cap;
		int entries;
		int count;
		int r;
		int tweak;
		logic [31:0] len;
		tbl.delete();
		for (int k = 0; k < 4; k++) tbl.push_back(SIGNATURE[8 * k +: 8]);
		repeat (40) tbl.push_back(8'($urandom));
		// every sixth table fills one cap: overrides, io controllers, processors
		cap = (serial % 6 == 5) ? (serial / 6) % 3 : 3;
		case (cap)
			0: entries = MAX_OVERRIDES + $urandom_range(1, 3);
			1: entries = MAX_IO_CONTROLLERS + $urandom_range(1, 2);
			2: entries = MAX_PROCESSORS + $urandom_range(1, 2);
			default: entries = $urandom_range(0, 10);
		endcase
		for (int e = 0; e < entries; e++) begin
			r = $urandom_range(99);
			if (cap == 0) add_entry(ENT_OVERRIDE, 10);
			else if (cap == 1) add_entry(ENT_IO_CTRL, 12);
			else if (cap == 2) add_entry(ENT_PROCESSOR, 8);
			else if (r < 30)
				add_entry(ENT_PROCESSOR, ($urandom_range(9) == 0) ? $urandom_range(2, 15) : 8);
			else if (r < 50)
				add_entry(ENT_IO_CTRL, ($urandom_range(9) == 0) ? $urandom_range(2, 20) : 12);
			else if (r < 75)
				add_entry(ENT_OVERRIDE, ($urandom_range(9) == 0) ? $urandom_range(2, 16) : 10);
			else if (r < 97)
				add_entry(8'($urandom_range(3, 255)), $urandom_range(2, 16));
			else
				add_entry(8'($urandom), $urandom_range(0, 1));
		end
		mode = (cap == 3) ? $urandom_range(99) : 0;
		len = tbl.size();
		count = tbl.size();
		if (mode >= 70 && mode < 76) len = $urandom_range(0, 43);
		else if (mode >= 76 && mode < 84) count = $urandom_range(1, tbl.size() - 1);
		else if (mode >= 84 && mode < 90) len = tbl.size() - $urandom_range(1, 8);
		else if (mode >= 95) len = {16'hFFFF, 16'($urandom)};
		seal_header(len);
		if (mode >= 55 && mode < 63) begin
			tweak = $urandom_range(10, count - 1);
			tbl[tweak] = tbl[tweak] + 8'($urandom_range(1, 255));
		end else if (mode >= 63 && mode < 70) begin
			tweak = $urandom_range(0, 3);
			tbl[tweak] = tbl[tweak] ^ 8'($urandom_range(1, 255));
		end else if (mode >= 90 && mode < 95) begin
			repeat ($urandom_range(1, 6)) tbl.push_back(8'($urandom));
			count = tbl.size();
		end
		send_table(count);
		repeat ($urandom_range(0, 4)) send_item(FUNC_QUERY, 8'($urandom), 1'($urandom), pick_irq());
	endtask

	initial begin
		req.valid <= 1'b0;
		req.func <= FUNC_BYTE;
		req.data_byte <= 8'd0;
		req.end_of_table <= 1'b0;
		req.irq <= 8'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty override store, then the short-table status cases
		send_item(FUNC_QUERY, 8'h00, 1'b0, 8'h00);
		send_item(FUNC_QUERY, 8'hFF, 1'b1, 8'hFF);
		tbl = '{8'hFF};
		send_table(1);
		tbl = '{SIGNATURE[7:0], SIGNATURE[15:8]};
		send_table(2);
		tbl = '{SIGNATURE[7:0], SIGNATURE[15:8], SIGNATURE[23:16], ~SIGNATURE[31:24],
			8'h2C, 8'h00};
		send_table(6);
		tbl = '{SIGNATURE[7:0], SIGNATURE[15:8], SIGNATURE[23:16], SIGNATURE[31:24],
			8'h2C, 8'h00, 8'h00};
		send_table(7);
		tbl = '{SIGNATURE[7:0], SIGNATURE[15:8], SIGNATURE[23:16], SIGNATURE[31:24],
			8'h2B, 8'h00, 8'h00, 8'h00};
		send_table(8);

		while (items_sent < ITEM_TARGET) begin
			if (items_sent < ITEM_TARGET / 3) begin
				src_idle_pct = 22;
				sink_idle_pct <= 71;
			end else if (items_sent < 2 * ITEM_TARGET / 3) begin
				src_idle_pct = 71;
				sink_idle_pct <= 22;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct <= 0;
			end
			send_random_table(tables_sent);
		end
		req.valid <= 1'b0;

		for (int k = 0; k < 100000 && book.pending() != 0; k++) @(posedge clk);
		repeat (20) @(posedge clk);
		book.close();

		$display("sent %0d req items in %0d tables, %0d lookups; compared %0d rsp items",
			items_sent, tables_sent, book.lookups, book.compared);
		$display("table outcomes: ok %0d, bad sig %0d, too short %0d, bad sum %0d, truncated %0d",
			book.status_count[0], book.status_count[1], book.status_count[2],
			book.status_count[3], book.status_count[4]);
		if (book.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule
